@@ hw/rtl/wmm_pkg.sv @@
// Shared constants for the windowed minimum / mean / maximum block.
`timescale 1ns / 1ps

package wmm_pkg;

    // Default sample and count widths
    localparam int SAMPLE_BITS_DEFAULT = 10;
    localparam int COUNT_BITS_DEFAULT  = 16;

    // Fixed field widths
    localparam int TIME_BITS   = 32;
    localparam int PERIOD_BITS = 16;
    localparam int INDEX_BITS  = 16;

    // Configuration port
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam logic [APB_ADDR_BITS-3:0] REG_PERIOD = 1'b0;

    // Reset values
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 16'd100;
    localparam logic [INDEX_BITS-1:0]  INDEX_RESET  = 16'd1;

    // Depth of the queue between front and back end
    localparam int QUEUE_DEPTH = 4;

endpackage

@@ hw/rtl/wmm_front.sv @@
// Front end: folds samples into the window statistics and queues closed windows.
`timescale 1ns / 1ps

module wmm_front #(
    parameter int SAMPLE_BITS = wmm_pkg::SAMPLE_BITS_DEFAULT,
    parameter int COUNT_BITS  = wmm_pkg::COUNT_BITS_DEFAULT,
    parameter int REC_W       = wmm_pkg::INDEX_BITS + 2 * COUNT_BITS + 3 * SAMPLE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [wmm_pkg::PERIOD_BITS-1:0]  period,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [SAMPLE_BITS-1:0]           in_sample,
    input  logic [wmm_pkg::TIME_BITS-1:0]    in_time,
    input  logic                             q_ready,
    output logic                             push,
    output logic [REC_W-1:0]                 push_data
);

    localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;

    typedef struct packed {
        logic [wmm_pkg::INDEX_BITS-1:0] wnum;
        logic [COUNT_BITS-1:0]          count;
        logic [SAMPLE_BITS-1:0]         vmin;
        logic [SUM_BITS-1:0]            sum;
        logic [SAMPLE_BITS-1:0]         vmax;
    } rec_t;

    logic [wmm_pkg::TIME_BITS-1:0]  origin_reg, origin_next;
    logic                           origin_set_reg, origin_set_next;
    logic [wmm_pkg::INDEX_BITS-1:0] wnum_reg, wnum_next;
    logic [COUNT_BITS-1:0]          count_reg, count_next;
    logic [SAMPLE_BITS-1:0]         min_reg, min_next;
    logic [SAMPLE_BITS-1:0]         max_reg, max_next;
    logic [SUM_BITS-1:0]            sum_reg, sum_next;

    logic                           accept;
    logic                           count_full;
    logic [COUNT_BITS-1:0]          count_fold;
    logic [SAMPLE_BITS-1:0]         min_fold;
    logic [SAMPLE_BITS-1:0]         max_fold;
    logic [SUM_BITS-1:0]            sum_fold;
    logic [wmm_pkg::TIME_BITS-1:0]  limit;
    logic                           close;
    rec_t                           rec;

    assign in_ready = q_ready;
    assign accept   = in_valid & q_ready;

    // Fold the sample; count and sum stop once the count saturates
    assign count_full = (count_reg == {COUNT_BITS{1'b1}});
    assign count_fold = count_full ? count_reg : count_reg + COUNT_BITS'(1);
    assign sum_fold   = count_full ? sum_reg : sum_reg + SUM_BITS'(in_sample);
    assign min_fold   = (in_sample < min_reg) ? in_sample : min_reg;
    assign max_fold   = (in_sample > max_reg) ? in_sample : max_reg;

    // Before the origin is placed the limit equals the item's own time
    assign limit = origin_set_reg ? origin_reg + wmm_pkg::TIME_BITS'(period) : in_time;
    assign close = (in_time > limit);

    always_comb
    begin
        rec.wnum  = wnum_reg;
        rec.count = count_fold;
        rec.vmin  = min_fold;
        rec.sum   = sum_fold;
        rec.vmax  = max_fold;
    end

    assign push      = accept & close;
    assign push_data = rec;

    // Advance window state on each transfer
    always_comb
    begin
        origin_next     = origin_reg;
        origin_set_next = origin_set_reg;
        wnum_next       = wnum_reg;
        count_next      = count_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        sum_next        = sum_reg;
        if (accept)
        begin
            origin_set_next = 1'b1;
            if (!origin_set_reg)
            begin
                origin_next = in_time - wmm_pkg::TIME_BITS'(period);
            end
            if (close)
            begin
                origin_next = limit;
                wnum_next   = wnum_reg + wmm_pkg::INDEX_BITS'(1);
                count_next  = '0;
                min_next    = {SAMPLE_BITS{1'b1}};
                max_next    = '0;
                sum_next    = '0;
            end
            else
            begin
                count_next = count_fold;
                min_next   = min_fold;
                max_next   = max_fold;
                sum_next   = sum_fold;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg     <= '0;
            origin_set_reg <= 1'b0;
            wnum_reg       <= wmm_pkg::INDEX_RESET;
            count_reg      <= '0;
            min_reg        <= {SAMPLE_BITS{1'b1}};
            max_reg        <= '0;
            sum_reg        <= '0;
        end
        else
        begin
            origin_reg     <= origin_next;
            origin_set_reg <= origin_set_next;
            wnum_reg       <= wnum_next;
            count_reg      <= count_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            sum_reg        <= sum_next;
        end
    end

    // A closing transfer leaves an empty window behind
    assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (count_reg == '0) && (sum_reg == '0))
        else $error("window not cleared after close");

    // The first transfer after reset never closes a window
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !origin_set_reg) |-> !close)
        else $error("window closed before origin placed");

endmodule

@@ hw/rtl/wmm_queue.sv @@
// Short queue of closed-window records between front and back end.
`timescale 1ns / 1ps

module wmm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH    = wmm_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] fill_reg, fill_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (fill_reg != CNT_BITS'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push & push_ready;
    assign do_pop     = pop & pop_valid;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                               : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                               : rd_ptr_reg + PTR_BITS'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the record; entries carry no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // A record offered while full would be lost
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_ready)
        else $error("push into full queue");

endmodule

@@ hw/rtl/wmm_back.sv @@
// Back end: serial mean division and the registered result stage.
`timescale 1ns / 1ps

module wmm_back #(
    parameter int SAMPLE_BITS = wmm_pkg::SAMPLE_BITS_DEFAULT,
    parameter int COUNT_BITS  = wmm_pkg::COUNT_BITS_DEFAULT,
    parameter int REC_W       = wmm_pkg::INDEX_BITS + 2 * COUNT_BITS + 3 * SAMPLE_BITS,
    parameter int RES_W       = wmm_pkg::INDEX_BITS + COUNT_BITS + 3 * SAMPLE_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  logic [REC_W-1:0] q_data,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [RES_W-1:0] out_data
);

    localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
    localparam int STEP_BITS = $clog2(SAMPLE_BITS);

    typedef struct packed {
        logic [wmm_pkg::INDEX_BITS-1:0] wnum;
        logic [COUNT_BITS-1:0]          count;
        logic [SAMPLE_BITS-1:0]         vmin;
        logic [SUM_BITS-1:0]            sum;
        logic [SAMPLE_BITS-1:0]         vmax;
    } rec_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                         state_reg, state_next;
    logic [STEP_BITS-1:0]           step_reg, step_next;
    logic [wmm_pkg::INDEX_BITS-1:0] wnum_reg, wnum_next;
    logic [COUNT_BITS-1:0]          div_reg, div_next;
    logic [SAMPLE_BITS-1:0]         vmin_reg, vmin_next;
    logic [SAMPLE_BITS-1:0]         vmax_reg, vmax_next;
    logic [COUNT_BITS-1:0]          rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0]         low_reg, low_next;
    logic [SAMPLE_BITS-1:0]         quo_reg, quo_next;
    logic                           out_valid_reg, out_valid_next;
    logic [RES_W-1:0]               out_data_reg, out_data_next;

    rec_t                           rec;
    logic [COUNT_BITS:0]            trial;
    logic                           fits;
    logic                           load_out;
    logic [SAMPLE_BITS-1:0]         mean;
    logic [SAMPLE_BITS-1:0]         res_min;
    logic [SAMPLE_BITS-1:0]         res_mean;
    logic [SAMPLE_BITS-1:0]         res_max;

    assign rec = q_data;

    // One restoring step: shift in the next dividend bit and try to subtract
    assign trial = {rem_reg, low_reg[SAMPLE_BITS-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    // An empty window would give a mean of zero
    assign mean     = (div_reg == '0) ? '0 : quo_reg;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign pop      = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        wnum_next      = wnum_reg;
        div_next       = div_reg;
        vmin_next      = vmin_reg;
        vmax_next      = vmax_reg;
        rem_next       = rem_reg;
        low_next       = low_reg;
        quo_next       = quo_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // Drop the result once it is taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    wnum_next  = rec.wnum;
                    div_next   = rec.count;
                    vmin_next  = rec.vmin;
                    vmax_next  = rec.vmax;
                    rem_next   = rec.sum[SUM_BITS-1:SAMPLE_BITS];
                    low_next   = rec.sum[SAMPLE_BITS-1:0];
                    quo_next   = '0;
                    step_next  = STEP_BITS'(SAMPLE_BITS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = fits ? COUNT_BITS'(trial - {1'b0, div_reg})
                                : trial[COUNT_BITS-1:0];
                low_next = {low_reg[SAMPLE_BITS-2:0], 1'b0};
                quo_next = {quo_reg[SAMPLE_BITS-2:0], fits};
                if (step_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg - STEP_BITS'(1);
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {vmax_reg, mean, vmin_reg, div_reg, wnum_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers carry no reset
    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        wnum_reg     <= wnum_next;
        div_reg      <= div_next;
        vmin_reg     <= vmin_next;
        vmax_reg     <= vmax_next;
        rem_reg      <= rem_next;
        low_reg      <= low_next;
        quo_reg      <= quo_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Field views of the held result
    assign res_min  = out_data_reg[wmm_pkg::INDEX_BITS + COUNT_BITS +: SAMPLE_BITS];
    assign res_mean = out_data_reg[wmm_pkg::INDEX_BITS + COUNT_BITS + SAMPLE_BITS +: SAMPLE_BITS];
    assign res_max  = out_data_reg[wmm_pkg::INDEX_BITS + COUNT_BITS + 2 * SAMPLE_BITS +: SAMPLE_BITS];

    // The partial remainder always stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_reg != '0) |-> (rem_reg < div_reg))
        else $error("partial remainder out of range");

    // A delivered mean lies between the window's extremes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_min <= res_mean) && (res_mean <= res_max))
        else $error("mean outside window range");

endmodule

@@ hw/rtl/windowed_min_mean_max.sv @@
// Top level of the windowed minimum / mean / maximum statistics block.
//
// Input stream (s_*): one converter sample with a millisecond time per transfer.
// Each transfer is folded into the current window's minimum, maximum, sum and
// count; when its time passes origin plus period the window closes, the origin
// moves on by one period and one summary is queued for the back end.
// Output stream (m_*): one summary per closed window: window number, count,
// minimum, truncated mean and maximum.
// Throughput: the front end takes one transfer per cycle while the queue has
// room. Each summary passes through the back end's load step, the bit-serial
// restoring divider and the result register, and the back end takes the next
// summary from the queue only after it has loaded the result register.
// A stalled receiver holds the result register; the back end then waits, the
// queue of QUEUE_DEPTH summaries fills, and only then is s_tready dropped.
// Reset clears the window, places the window number at one and the period at
// 100 ms; the first transfer afterwards sets the origin to its time minus the
// period. The period register sits at byte address 0 of the APB port.
`timescale 1ns / 1ps

module windowed_min_mean_max #(
    parameter int SAMPLE_BITS = wmm_pkg::SAMPLE_BITS_DEFAULT,
    parameter int COUNT_BITS  = wmm_pkg::COUNT_BITS_DEFAULT,
    parameter int IN_W        = ((SAMPLE_BITS + wmm_pkg::TIME_BITS + 7) / 8) * 8,
    parameter int OUT_W       = ((wmm_pkg::INDEX_BITS + COUNT_BITS + 3 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wmm_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [wmm_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [wmm_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    // Sample stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [IN_W-1:0]                   s_tdata,  // sample_value, time_ms
    // Summary stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_W-1:0]                  m_tdata   // window_index, read_count,
                                                        // min_value, mean_value, max_value
);

    localparam int REC_W = wmm_pkg::INDEX_BITS + 2 * COUNT_BITS + 3 * SAMPLE_BITS;
    localparam int RES_W = wmm_pkg::INDEX_BITS + COUNT_BITS + 3 * SAMPLE_BITS;

    logic [wmm_pkg::PERIOD_BITS-1:0] period_reg, period_next;
    logic                            cfg_write;
    logic                            sel_period;
    logic                            q_ready;
    logic                            push;
    logic [REC_W-1:0]                push_data;
    logic                            pop;
    logic                            q_valid;
    logic [REC_W-1:0]                q_data;
    logic [RES_W-1:0]                res_data;

    // Register decode: index is the byte address over four
    assign pready     = 1'b1;
    assign sel_period = (paddr[wmm_pkg::APB_ADDR_BITS-1:2] == wmm_pkg::REG_PERIOD);
    assign cfg_write  = psel & penable & pwrite & pready;

    always_comb
    begin
        period_next = period_reg;
        if (cfg_write && sel_period)
        begin
            period_next = pwdata[wmm_pkg::PERIOD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= wmm_pkg::PERIOD_RESET;
        end
        else
        begin
            period_reg <= period_next;
        end
    end

    assign prdata = sel_period ? wmm_pkg::APB_DATA_BITS'(period_reg) : '0;

    wmm_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .REC_W       (REC_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .period    (period_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata[SAMPLE_BITS-1:0]),
        .in_time   (s_tdata[SAMPLE_BITS +: wmm_pkg::TIME_BITS]),
        .q_ready   (q_ready),
        .push      (push),
        .push_data (push_data)
    );

    wmm_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (q_ready),
        .pop        (pop),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    wmm_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .REC_W       (REC_W),
        .RES_W       (RES_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_data)
    );

    // Pad the summary up to whole bytes
    assign m_tdata = OUT_W'(res_data);

endmodule
